/* src/rcc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, codes and constants of the RGB convolution with clamped edge.
// ----------------------------------------------------------------------------
package rcc_pkg;

    localparam int DEF_MAX_KERNEL = 7;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_COEFF_FRAC = 10;

    localparam int MAX_HEIGHT     = 4096;
    localparam int PIX_W          = 8;
    localparam int RGB_W          = 3 * PIX_W;
    localparam int COEFF_W        = 18;
    localparam int CIDX_W         = 6;
    localparam int OP_W           = 2;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int WREG_W         = 11;
    localparam int HREG_W         = 13;
    localparam int KREG_W         = 3;

    localparam int RST_WIDTH      = 640;
    localparam int RST_HEIGHT     = 480;
    localparam int RST_KSIZE      = 3;

    localparam int FIFO_DEPTH     = 16;

    localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAIN = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KSIZE  = 2'd2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic valid;
        logic bcast;
        logic fin;
        logic last;
    } t_col_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } t_result;

endpackage
`default_nettype wire

/* src/rgb_convolution_clamp_edge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_convolution_clamp_edge
// Streaming RGB convolution with a square kernel and replicated frame border.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while o_stall is low. Pixels are stored in a banked
// row store, one bank per buffered row; each output reads one new window
// column from all banks at once. The first output of every row needs its
// window columns loaded one by one (K = kernel side), and the input stalls
// meanwhile because each bank has one read port. Up to FIFO_DEPTH results
// queue at the output. A coefficient load waits until no result is in flight
// or queued. Outputs trail inputs by (K/2)*W + K/2 pixels; drain beats flush
// them after the frame.
// ----------------------------------------------------------------------------
module rgb_convolution_clamp_edge #(
    parameter int MAX_KERNEL      = rcc_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH       = rcc_pkg::DEF_MAX_WIDTH,
    parameter int COEFF_FRAC_BITS = rcc_pkg::DEF_COEFF_FRAC
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [rcc_pkg::OP_W-1:0]            i_operation,
    input  wire logic [rcc_pkg::PIX_W-1:0]           i_pixel_red,
    input  wire logic [rcc_pkg::PIX_W-1:0]           i_pixel_green,
    input  wire logic [rcc_pkg::PIX_W-1:0]           i_pixel_blue,
    input  wire logic [rcc_pkg::CIDX_W-1:0]          i_coeff_index,
    input  wire logic signed [rcc_pkg::COEFF_W-1:0]  i_coeff_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [rcc_pkg::PIX_W-1:0]                o_out_red,
    output logic [rcc_pkg::PIX_W-1:0]                o_out_green,
    output logic [rcc_pkg::PIX_W-1:0]                o_out_blue,
    output logic                                     o_last_of_frame,
    input  wire logic                                i_cfg_we,
    input  wire logic [rcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [rcc_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int HM    = MAX_KERNEL / 2;
    localparam int NB    = 3 * HM + 2;
    localparam int BW    = $clog2(NB);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WBW   = CW + 1;
    localparam int HW    = rcc_pkg::HREG_W;
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int TAPS  = MAX_KERNEL * MAX_KERNEL;
    localparam int LINW  = WBW + HW;
    localparam int FD    = rcc_pkg::FIFO_DEPTH;
    localparam int CRW   = $clog2(FD + 1);
    localparam int RST_W = (rcc_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : rcc_pkg::RST_WIDTH;
    localparam int RST_K = (rcc_pkg::RST_KSIZE > MAX_KERNEL) ? MAX_KERNEL
                                                            : rcc_pkg::RST_KSIZE;

    logic [WBW-1:0]  r_w;
    logic [HW-1:0]   r_h;
    logic [KW-1:0]   r_k;
    logic [KW-1:0]   w_half, w_hr;
    logic [LINW-1:0] w_lag;

    logic [CW-1:0]   r_in_col, r_out_col;
    logic [HW-1:0]   r_in_row, r_out_row;
    logic [BW-1:0]   r_in_bank, r_out_bank;
    logic [LINW-1:0] r_in_lin;

    logic signed [rcc_pkg::COEFF_W-1:0] r_coef [TAPS];

    logic [CRW-1:0]  r_credit;

    rcc_pkg::t_col_ctl r_s1_ctl;
    logic [CW-1:0]     r_s1_col;
    logic [KW-1:0]     r_s1_left;
    logic [BW-1:0]     r_s1_sel [MAX_KERNEL];
    logic [BW-1:0]     n_sel    [MAX_KERNEL];

    logic w_acc, w_complete, w_pix_take, w_emit, w_load, w_last, w_cfg_hit, w_pop, w_busy;
    logic [WBW-1:0] w_csum, w_first_col, w_next_col;

    rcc_pkg::t_col_ctl         w_mem_ctl;
    logic [rcc_pkg::RGB_W-1:0] w_column [MAX_KERNEL];
    logic                      w_res_valid;
    rcc_pkg::t_result          w_res, w_head;

    // effective geometry
    assign w_half = r_k >> 1;
    assign w_hr   = r_k - KW'(1) - w_half;
    assign w_lag  = LINW'(w_half) * LINW'(r_w) + LINW'(w_half);

    // handshake
    assign w_busy     = r_s1_ctl.valid && (r_s1_left != '0);
    assign o_stall    = (r_credit == CRW'(FD)) || w_busy
                        || (i_operation == rcc_pkg::OP_LOAD && r_credit != '0);
    assign w_acc      = i_valid && !o_stall;
    assign w_complete = (r_in_row >= r_h);
    assign w_pix_take = w_acc && i_operation == rcc_pkg::OP_PIXEL && !w_complete;
    assign w_emit     = (w_pix_take && r_in_lin >= w_lag)
                        || (w_acc && i_operation == rcc_pkg::OP_DRAIN && w_complete);
    assign w_load     = w_acc && i_operation == rcc_pkg::OP_LOAD
                        && int'(i_coeff_index) < TAPS;
    assign w_last     = (r_out_row == r_h - HW'(1)) && ({1'b0, r_out_col} == r_w - WBW'(1));
    assign w_cfg_hit  = i_cfg_we && (i_cfg_index == rcc_pkg::CFG_WIDTH
                        || i_cfg_index == rcc_pkg::CFG_HEIGHT
                        || i_cfg_index == rcc_pkg::CFG_KSIZE);
    assign w_pop      = o_valid && !i_stall;

    // window column addressing
    assign w_csum      = {1'b0, r_out_col} + WBW'(w_hr);
    assign w_first_col = (r_out_col == '0) ? '0
                         : ((w_csum >= r_w) ? r_w - WBW'(1) : w_csum);
    assign w_next_col  = ({1'b0, r_s1_col} + WBW'(1) >= r_w) ? r_w - WBW'(1)
                         : {1'b0, r_s1_col} + WBW'(1);

    // row bank per window row, clamped to the frame
    always_comb begin
        int dy;
        int rr;
        int bb;
        for (int y = 0; y < MAX_KERNEL; y++) begin
            dy = y - int'(w_half);
            rr = int'(r_out_row);
            if (rr + dy < 0) begin
                dy = -rr;
            end else if (rr + dy > int'(r_h) - 1) begin
                dy = int'(r_h) - 1 - rr;
            end
            bb = int'(r_out_bank) + dy;
            if (bb < 0) begin
                bb = bb + NB;
            end else if (bb >= NB) begin
                bb = bb - NB;
            end
            if (y >= int'(r_k)) begin
                bb = int'(r_out_bank);
            end
            n_sel[y] = BW'(bb);
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WBW'(RST_W);
            r_h <= HW'(rcc_pkg::RST_HEIGHT);
            r_k <= KW'(RST_K);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rcc_pkg::CFG_WIDTH: begin
                    if (i_cfg_data[rcc_pkg::WREG_W-1:0] == '0) begin
                        r_w <= WBW'(1);
                    end else if (int'(i_cfg_data[rcc_pkg::WREG_W-1:0]) > MAX_WIDTH) begin
                        r_w <= WBW'(MAX_WIDTH);
                    end else begin
                        r_w <= WBW'(i_cfg_data[rcc_pkg::WREG_W-1:0]);
                    end
                end
                rcc_pkg::CFG_HEIGHT: begin
                    if (i_cfg_data[rcc_pkg::HREG_W-1:0] == '0) begin
                        r_h <= HW'(1);
                    end else if (int'(i_cfg_data[rcc_pkg::HREG_W-1:0])
                                 > rcc_pkg::MAX_HEIGHT) begin
                        r_h <= HW'(rcc_pkg::MAX_HEIGHT);
                    end else begin
                        r_h <= i_cfg_data[rcc_pkg::HREG_W-1:0];
                    end
                end
                rcc_pkg::CFG_KSIZE: begin
                    if (i_cfg_data[rcc_pkg::KREG_W-1:0] == '0) begin
                        r_k <= KW'(1);
                    end else if (int'(i_cfg_data[rcc_pkg::KREG_W-1:0]) > MAX_KERNEL) begin
                        r_k <= KW'(MAX_KERNEL);
                    end else begin
                        r_k <= KW'(i_cfg_data[rcc_pkg::KREG_W-1:0]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit || (w_emit && w_last)) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_bank  <= '0;
            r_in_lin   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_bank <= '0;
        end else begin
            if (w_pix_take) begin
                r_in_lin <= r_in_lin + LINW'(1);
                if ({1'b0, r_in_col} + WBW'(1) >= r_w) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + HW'(1);
                    r_in_bank <= (r_in_bank == BW'(NB - 1)) ? '0 : r_in_bank + BW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
            if (w_emit) begin
                if ({1'b0, r_out_col} + WBW'(1) >= r_w) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + HW'(1);
                    r_out_bank <= (r_out_bank == BW'(NB - 1)) ? '0 : r_out_bank + BW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // coefficients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) begin
                r_coef[t] <= '0;
            end
        end else begin
            for (int t = 0; t < TAPS; t++) begin
                if (w_load && int'(i_coeff_index) == t) begin
                    r_coef[t] <= i_coeff_value;
                end
            end
        end
    end

    // column read sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl  <= '0;
            r_s1_left <= '0;
        end else if (w_busy) begin
            r_s1_left     <= r_s1_left - KW'(1);
            r_s1_ctl.bcast <= 1'b0;
            r_s1_ctl.fin  <= (r_s1_left == KW'(1));
        end else if (w_emit) begin
            r_s1_ctl.valid <= 1'b1;
            r_s1_ctl.bcast <= (r_out_col == '0);
            r_s1_ctl.fin   <= (r_out_col != '0) || (w_hr == '0);
            r_s1_ctl.last  <= w_last;
            r_s1_left      <= (r_out_col == '0) ? w_hr : '0;
        end else begin
            r_s1_ctl.valid <= 1'b0;
            r_s1_left      <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_busy) begin
            r_s1_col <= w_next_col[CW-1:0];
        end else if (w_emit) begin
            r_s1_col <= w_first_col[CW-1:0];
            r_s1_sel <= n_sel;
        end
    end

    // results in flight or queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CRW'(w_emit) - CRW'(w_pop);
        end
    end

    rcc_row_mem #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .NB         (NB),
        .BW         (BW),
        .CW         (CW)
    ) u_row_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_pix_take),
        .i_wbank  (r_in_bank),
        .i_wcol   (r_in_col),
        .i_wdata  ({i_pixel_red, i_pixel_green, i_pixel_blue}),
        .i_rcol   (r_s1_col),
        .i_rsel   (r_s1_sel),
        .i_ctl    (r_s1_ctl),
        .o_ctl    (w_mem_ctl),
        .o_column (w_column)
    );

    rcc_mac #(
        .MAX_KERNEL      (MAX_KERNEL),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
        .KW              (KW),
        .TAPS            (TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mem_ctl),
        .i_column (w_column),
        .i_k      (r_k),
        .i_coef   (r_coef),
        .o_valid  (w_res_valid),
        .o_result (w_res)
    );

    rcc_out_fifo #(
        .DEPTH (FD)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .i_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (w_head)
    );

    assign o_out_red       = w_head.red;
    assign o_out_green     = w_head.green;
    assign o_out_blue      = w_head.blue;
    assign o_last_of_frame = w_head.last;

endmodule
`default_nettype wire

/* src/rcc_row_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_row_mem
// Banked row store: one bank per buffered row, all banks read at one column.
// ----------------------------------------------------------------------------
module rcc_row_mem #(
    parameter int MAX_KERNEL = rcc_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH  = rcc_pkg::DEF_MAX_WIDTH,
    parameter int NB         = 3 * (MAX_KERNEL / 2) + 2,
    parameter int BW         = $clog2(NB),
    parameter int CW         = $clog2(MAX_WIDTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_we,
    input  wire logic [BW-1:0]              i_wbank,
    input  wire logic [CW-1:0]              i_wcol,
    input  wire logic [rcc_pkg::RGB_W-1:0]  i_wdata,
    input  wire logic [CW-1:0]              i_rcol,
    input  wire logic [BW-1:0]              i_rsel [MAX_KERNEL],
    input  wire rcc_pkg::t_col_ctl          i_ctl,
    output rcc_pkg::t_col_ctl               o_ctl,
    output logic [rcc_pkg::RGB_W-1:0]       o_column [MAX_KERNEL]
);

    logic [rcc_pkg::RGB_W-1:0] w_rd [NB];
    logic [BW-1:0]             r_sel [MAX_KERNEL];
    rcc_pkg::t_col_ctl         r_ctl;

    for (genvar b = 0; b < NB; b++) begin : g_bank
        logic [rcc_pkg::RGB_W-1:0] r_mem [MAX_WIDTH];
        logic [rcc_pkg::RGB_W-1:0] r_q;
        always_ff @(posedge i_clk) begin
            if (i_we && i_wbank == BW'(b)) begin
                r_mem[i_wcol] <= i_wdata;
            end
            r_q <= r_mem[i_rcol];
        end
        assign w_rd[b] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_sel <= i_rsel;
    end

    always_comb begin
        for (int y = 0; y < MAX_KERNEL; y++) begin
            o_column[y] = w_rd[r_sel[y]];
        end
    end

    assign o_ctl = r_ctl;

endmodule
`default_nettype wire

/* src/rcc_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_mac
// Window registers, parallel tap multiplies, registered adder tree, saturation.
// ----------------------------------------------------------------------------
module rcc_mac #(
    parameter int MAX_KERNEL      = rcc_pkg::DEF_MAX_KERNEL,
    parameter int COEFF_FRAC_BITS = rcc_pkg::DEF_COEFF_FRAC,
    parameter int KW              = $clog2(MAX_KERNEL + 1),
    parameter int TAPS            = MAX_KERNEL * MAX_KERNEL
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rcc_pkg::t_col_ctl                   i_ctl,
    input  wire logic [rcc_pkg::RGB_W-1:0]           i_column [MAX_KERNEL],
    input  wire logic [KW-1:0]                       i_k,
    input  wire logic signed [rcc_pkg::COEFF_W-1:0]  i_coef [TAPS],
    output logic                                     o_valid,
    output rcc_pkg::t_result                         o_result
);

    localparam int PRW   = rcc_pkg::PIX_W + 1 + rcc_pkg::COEFF_W;
    localparam int ACC_W = PRW + $clog2(TAPS) + 1;
    localparam int PW    = rcc_pkg::PIX_W;

    logic [rcc_pkg::RGB_W-1:0]         r_win  [MAX_KERNEL][MAX_KERNEL];
    logic signed [rcc_pkg::COEFF_W-1:0] r_cm  [MAX_KERNEL][MAX_KERNEL];
    logic signed [rcc_pkg::COEFF_W-1:0] n_cm  [MAX_KERNEL][MAX_KERNEL];
    logic signed [PRW-1:0]             r_prod [3][MAX_KERNEL][MAX_KERNEL];
    logic signed [ACC_W-1:0]           r_rsum [3][MAX_KERNEL];
    logic signed [ACC_W-1:0]           n_rsum [3][MAX_KERNEL];
    logic signed [ACC_W-1:0]           n_tot  [3];
    logic [PW-1:0]                     n_sat  [3];
    logic                              r_s3_valid, r_s4_valid, r_s5_valid, r_s6_valid;
    logic                              r_s3_last, r_s4_last, r_s5_last;
    rcc_pkg::t_result                  r_res;

    // tap to coefficient mapping for the kernel side in use
    always_comb begin
        for (int y = 0; y < MAX_KERNEL; y++) begin
            for (int x = 0; x < MAX_KERNEL; x++) begin
                n_cm[y][x] = '0;
                for (int kk = 1; kk <= MAX_KERNEL; kk++) begin
                    if (i_k == KW'(kk) && y < kk && x >= MAX_KERNEL - kk) begin
                        n_cm[y][x] = i_coef[y * kk + x - (MAX_KERNEL - kk)];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < MAX_KERNEL; y++) begin
                for (int x = 0; x < MAX_KERNEL; x++) begin
                    r_win[y][x] <= '0;
                    r_cm[y][x]  <= '0;
                end
            end
        end else begin
            r_cm <= n_cm;
            if (i_ctl.valid) begin
                for (int y = 0; y < MAX_KERNEL; y++) begin
                    for (int x = 0; x < MAX_KERNEL; x++) begin
                        if (i_ctl.bcast || x == MAX_KERNEL - 1) begin
                            r_win[y][x] <= (y < int'(i_k)) ? i_column[y] : '0;
                        end else begin
                            r_win[y][x] <= r_win[y][x + 1];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_ctl.valid && i_ctl.fin;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
        end
        r_s3_last <= i_ctl.last;
        r_s4_last <= r_s3_last;
        r_s5_last <= r_s4_last;
    end

    // products
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            for (int y = 0; y < MAX_KERNEL; y++) begin
                for (int x = 0; x < MAX_KERNEL; x++) begin
                    r_prod[c][y][x] <= PRW'($signed({1'b0, r_win[y][x][PW*(2-c) +: PW]}))
                                       * PRW'(r_cm[y][x]);
                end
            end
        end
    end

    // row sums
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int y = 0; y < MAX_KERNEL; y++) begin
                n_rsum[c][y] = '0;
                for (int x = 0; x < MAX_KERNEL; x++) begin
                    n_rsum[c][y] = n_rsum[c][y] + ACC_W'(r_prod[c][y][x]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsum <= n_rsum;
    end

    // column sum and saturation
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_tot[c] = '0;
            for (int y = 0; y < MAX_KERNEL; y++) begin
                n_tot[c] = n_tot[c] + r_rsum[c][y];
            end
            if (n_tot[c][ACC_W-1]) begin
                n_sat[c] = '0;
            end else if (|n_tot[c][ACC_W-2:COEFF_FRAC_BITS+PW]) begin
                n_sat[c] = rcc_pkg::PIX_MAX;
            end else begin
                n_sat[c] = n_tot[c][COEFF_FRAC_BITS +: PW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.red   <= n_sat[0];
        r_res.green <= n_sat[1];
        r_res.blue  <= n_sat[2];
        r_res.last  <= r_s5_last;
    end

    assign o_valid  = r_s6_valid;
    assign o_result = r_res;

endmodule
`default_nettype wire

/* src/rcc_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_out_fifo
// Result queue between the arithmetic pipeline and the output channel.
// ----------------------------------------------------------------------------
module rcc_out_fifo #(
    parameter int DEPTH = rcc_pkg::FIFO_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rcc_pkg::t_result  i_data,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output rcc_pkg::t_result       o_data
);

    localparam int AW = $clog2(DEPTH);

    rcc_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

endmodule
`default_nettype wire
